// ===== hdl/salsa_pkg.sv =====
// Shared types, constants and the quarter-round function of the Salsa20 stream cipher.
package salsa_pkg;

  typedef logic [31:0] word_t;

  // One quarter-round column: words a, b, c, d in the order of the quad table.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // Matrix constants, "expand 32-byte k".
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY01 = 3'd0;
  localparam logic [2:0] CFG_KEY23 = 3'd1;
  localparam logic [2:0] CFG_KEY45 = 3'd2;
  localparam logic [2:0] CFG_KEY67 = 3'd3;
  localparam logic [2:0] CFG_NONCE = 3'd4;

  // Word indexes of the quarter rounds: four for the column round, four for the row round.
  localparam logic [3:0] QUAD [8][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic round_en;
    logic row_sel;
    logic add;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_zero;
    logic out_busy;
  } sts_t;

  // Salsa20 quarter round: four dependent add, rotate and XOR steps.
  function automatic quad_t quarter(quad_t x);
    word_t t;
    quad_t y;
    t   = x.a + x.d;
    y.b = x.b ^ {t[24:0], t[31:25]};
    t   = y.b + x.a;
    y.c = x.c ^ {t[22:0], t[31:23]};
    t   = y.c + y.b;
    y.d = x.d ^ {t[18:0], t[31:19]};
    t   = y.d + y.c;
    y.a = x.a ^ {t[13:0], t[31:14]};
    return y;
  endfunction

endpackage

// ===== hdl/salsa_ctrl.sv =====
// Controller state machine of the Salsa20 stream cipher: sequences block generation and output.
module salsa_ctrl #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  salsa_pkg::sts_t sts,
  output salsa_pkg::cmd_t cmd
);

  localparam int RW = (2 * DOUBLE_ROUNDS > 1) ? $clog2(2 * DOUBLE_ROUNDS) : 1;

  salsa_pkg::state_t state, state_next;
  logic [RW-1:0]     rnd;
  logic              last_round;
  logic              accept;

  assign last_round = (rnd == RW'(2 * DOUBLE_ROUNDS - 1));
  assign accept     = s_axis_tvalid && (state == salsa_pkg::S_IDLE);

  // State register and round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salsa_pkg::S_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == salsa_pkg::S_LOAD) begin
        rnd <= '0;
      end else if (state == salsa_pkg::S_ROUND) begin
        rnd <= rnd + 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      salsa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = sts.pos_zero ? salsa_pkg::S_LOAD : salsa_pkg::S_EMIT;
        end
      end
      salsa_pkg::S_LOAD:  state_next = salsa_pkg::S_ROUND;
      salsa_pkg::S_ROUND: begin
        if (last_round) begin
          state_next = salsa_pkg::S_ADD;
        end
      end
      salsa_pkg::S_ADD:   state_next = salsa_pkg::S_EMIT;
      salsa_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          state_next = salsa_pkg::S_IDLE;
        end
      end
      default: state_next = salsa_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    case (state)
      salsa_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.capture   = s_axis_tvalid;
      end
      salsa_pkg::S_LOAD:  cmd.load = 1'b1;
      salsa_pkg::S_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.row_sel  = rnd[0];
      end
      salsa_pkg::S_ADD:   cmd.add = 1'b1;
      salsa_pkg::S_EMIT:  cmd.emit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  // The round counter stays in range and a block always runs its full count of rounds.
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    (state == salsa_pkg::S_ROUND) |-> (rnd <= RW'(2 * DOUBLE_ROUNDS - 1)))
    else $error("round counter beyond the last round");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == salsa_pkg::S_ADD) |-> ($past(state) == salsa_pkg::S_ROUND && $past(last_round)))
    else $error("final addition without a completed round sequence");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    (state == salsa_pkg::S_ROUND && $past(state) != salsa_pkg::S_ROUND) |-> (rnd == '0))
    else $error("round sequence did not start at round zero");

endmodule

// ===== hdl/salsa_dp.sv =====
// Datapath of the Salsa20 stream cipher: registers, round unit, keystream and output stage.
module salsa_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic [63:0]      msg_data,
  input  logic [3:0]       byte_count,
  input  logic             last,
  input  salsa_pkg::cmd_t  cmd,
  output salsa_pkg::sts_t  sts,
  output logic [63:0]      cipher_data,
  output logic [3:0]       out_byte_count,
  output logic             out_last,
  output logic             out_valid,
  input  logic             out_ready
);

  logic [63:0] key01, key23, key45, key67, nonce;
  logic [63:0] block_counter;
  logic [2:0]  word_position;

  logic [63:0] item_msg;
  logic [3:0]  item_count;
  logic        item_last;

  salsa_pkg::word_t round_state [16];
  salsa_pkg::word_t matrix      [16];
  salsa_pkg::word_t col_next    [16];
  salsa_pkg::word_t row_next    [16];
  logic [63:0]      keystream   [8];

  logic [63:0] ks_sel;
  logic [63:0] byte_mask;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key01 <= '0;
      key23 <= '0;
      key45 <= '0;
      key67 <= '0;
      nonce <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        salsa_pkg::CFG_KEY01: key01 <= cfg_data;
        salsa_pkg::CFG_KEY23: key23 <= cfg_data;
        salsa_pkg::CFG_KEY45: key45 <= cfg_data;
        salsa_pkg::CFG_KEY67: key67 <= cfg_data;
        salsa_pkg::CFG_NONCE: nonce <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input matrix in the published layout.
  always_comb begin
    matrix[0]  = salsa_pkg::SIGMA0;
    matrix[1]  = key01[31:0];
    matrix[2]  = key01[63:32];
    matrix[3]  = key23[31:0];
    matrix[4]  = key23[63:32];
    matrix[5]  = salsa_pkg::SIGMA1;
    matrix[6]  = nonce[31:0];
    matrix[7]  = nonce[63:32];
    matrix[8]  = block_counter[31:0];
    matrix[9]  = block_counter[63:32];
    matrix[10] = salsa_pkg::SIGMA2;
    matrix[11] = key45[31:0];
    matrix[12] = key45[63:32];
    matrix[13] = key67[31:0];
    matrix[14] = key67[63:32];
    matrix[15] = salsa_pkg::SIGMA3;
  end

  // Column round and row round, four quarter rounds side by side in each.
  always_comb begin
    salsa_pkg::quad_t qi;
    salsa_pkg::quad_t qo;
    col_next = round_state;
    row_next = round_state;
    for (int q = 0; q < 4; q++) begin
      qi = '{round_state[salsa_pkg::QUAD[q][0]], round_state[salsa_pkg::QUAD[q][1]],
             round_state[salsa_pkg::QUAD[q][2]], round_state[salsa_pkg::QUAD[q][3]]};
      qo = salsa_pkg::quarter(qi);
      col_next[salsa_pkg::QUAD[q][0]] = qo.a;
      col_next[salsa_pkg::QUAD[q][1]] = qo.b;
      col_next[salsa_pkg::QUAD[q][2]] = qo.c;
      col_next[salsa_pkg::QUAD[q][3]] = qo.d;
      qi = '{round_state[salsa_pkg::QUAD[q+4][0]], round_state[salsa_pkg::QUAD[q+4][1]],
             round_state[salsa_pkg::QUAD[q+4][2]], round_state[salsa_pkg::QUAD[q+4][3]]};
      qo = salsa_pkg::quarter(qi);
      row_next[salsa_pkg::QUAD[q+4][0]] = qo.a;
      row_next[salsa_pkg::QUAD[q+4][1]] = qo.b;
      row_next[salsa_pkg::QUAD[q+4][2]] = qo.c;
      row_next[salsa_pkg::QUAD[q+4][3]] = qo.d;
    end
  end

  // Working matrix and keystream block.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      round_state <= matrix;
    end else if (cmd.round_en) begin
      round_state <= cmd.row_sel ? row_next : col_next;
    end
    if (cmd.add) begin
      for (int k = 0; k < 8; k++) begin
        keystream[k] <= {round_state[2*k+1] + matrix[2*k+1], round_state[2*k] + matrix[2*k]};
      end
    end
  end

  // Held input word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_msg   <= msg_data;
      item_count <= byte_count;
      item_last  <= last;
    end
  end

  // Keystream selection and byte mask; counts of eight and above keep every byte.
  assign ks_sel = keystream[word_position];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (item_count > 4'(i)) ? 8'hff : 8'h00;
    end
  end

  // Block counter and position within the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      word_position <= '0;
    end else if (cmd.emit) begin
      if (item_last) begin
        block_counter <= '0;
        word_position <= '0;
      end else begin
        word_position <= word_position + 1'b1;
        if (word_position == 3'd7) begin
          block_counter <= block_counter + 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cipher_data    <= (item_msg ^ ks_sel) & byte_mask;
      out_byte_count <= item_count;
      out_last       <= item_last;
    end
  end

  assign sts.pos_zero = (word_position == 3'd0);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

// ===== hdl/salsa20_stream_cipher_top.sv =====
// Top level of the Salsa20 stream cipher: streaming ports, configuration port, controller and datapath.
//
// Each input word carries eight message bytes and leaves as one result word of the same bytes
// XORed with the keystream, bytes beyond the count cleared. The first word of every 64-byte
// block is accepted, loads the matrix, runs the 2*DOUBLE_ROUNDS column and row rounds in turn
// in a round unit that holds four quarter rounds side by side, passes the final addition and is
// emitted. The other seven words of a block are accepted and emitted with no rounds; a word is
// only accepted once the one before it has been emitted. A result waits in the output register
// while the next word is accepted; emitting stalls only while that register is still full.
// Configuration writes are always taken at once; they belong in gaps with no word in flight,
// since the matrix is read both when a block is loaded and at its final addition, and they act
// from the next block start. A last word returns the block counter and position to zero.
module salsa20_stream_cipher_top #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // msg_data [63:0], byte_count [67:64], zero [71:68]
  input  logic        s_axis_tlast,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // cipher_data [63:0], out_byte_count [67:64], zero [71:68]
  output logic        m_axis_tlast
);

  salsa_pkg::cmd_t cmd;
  salsa_pkg::sts_t sts;
  logic [63:0]     cipher_data;
  logic [3:0]      out_byte_count;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {4'b0000, out_byte_count, cipher_data};

  salsa_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  salsa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .msg_data       (s_axis_tdata[63:0]),
    .byte_count     (s_axis_tdata[67:64]),
    .last           (s_axis_tlast),
    .cmd            (cmd),
    .sts            (sts),
    .cipher_data    (cipher_data),
    .out_byte_count (out_byte_count),
    .out_last       (m_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready)
  );

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while full");

  // A new keystream block is only built at the start of a block.
  a_load_at_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.pos_zero)
    else $error("keystream block built away from a block start");

  // After the last word of a message the position is back at zero.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (!m_axis_tlast || sts.pos_zero))
    else $error("position not cleared after a last word");

endmodule
